>>> hdl/hilb9_pkg.sv
// Shared types, constants and the axis step function of the Hilbert transcoder.
`timescale 1ns / 1ps

package hilb9_pkg;

  localparam int COORD_W  = 7;   // coordinate port width
  localparam int IDX_W    = 63;  // Hilbert index port width
  localparam int ORD_W    = 3;   // curve order register width
  localparam int MAX_DIMS = 9;   // coordinate ports on the block
  localparam int DIM_IW   = 4;   // index into a coordinate array

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_COORD_ERR = 2'd1;
  localparam status_t ST_INDEX_ERR = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [MAX_DIMS-1:0] coord_arr_t;

  // One request as it travels down the pipe.
  typedef struct packed {
    logic       dec;     // 1: index to coordinates
    status_t    status;
    coord_arr_t x;       // transposed working vector
  } stage_t;

  // One finished result.
  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] index;
    coord_arr_t       pos;
  } res_t;

  // Exchange or flip the bits below q between axis 0 and axis i.
  function automatic coord_arr_t axis_step(coord_arr_t x, logic [DIM_IW-1:0] i, coord_t q);
    coord_arr_t y;
    coord_t     p;
    coord_t     t;
    y = x;
    p = q - coord_t'(1);
    if ((x[i] & q) != '0) begin
      y[0] = x[0] ^ p;
    end else begin
      t    = (x[0] ^ x[i]) & p;
      y[0] = x[0] ^ t;
      y[i] = x[i] ^ t;
    end
    return y;
  endfunction

endpackage

>>> hdl/hilb9_front.sv
// Entry stage: range check, index unpacking and inverse Gray step for decode.
`timescale 1ns / 1ps

module hilb9_front #(
  parameter int NUM_DIMS  = 9,
  parameter int MAX_ORDER = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [hilb9_pkg::ORD_W-1:0]        ord,
  input  logic                               vld_i,
  output logic                               ready_o,
  input  logic                               req_type,
  input  hilb9_pkg::coord_arr_t              coord_i,
  input  logic [hilb9_pkg::IDX_W-1:0]        index_i,
  output logic                               vld_o,
  input  logic                               ready_i,
  output hilb9_pkg::stage_t                  d_o
);
  import hilb9_pkg::*;

  logic          vld_r;
  stage_t        d_r;
  stage_t        d_nxt;
  logic [COORD_W:0] lim;
  logic          over;
  coord_t        t;

  always_comb begin
    d_nxt     = '0;
    d_nxt.dec = req_type;
    over      = 1'b0;
    t         = '0;
    lim       = (COORD_W+1)'(1) << ord;
    if (!req_type) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        d_nxt.x[i] = coord_i[i];
        if ({1'b0, coord_i[i]} >= lim) over = 1'b1;
      end
      d_nxt.status = over ? ST_COORD_ERR : ST_OK;
    end else begin
      for (int j = 0; j < IDX_W; j++) begin
        if (index_i[j] && (j >= NUM_DIMS * int'(ord))) over = 1'b1;
      end
      // dimension 0 holds the more significant bit of each level
      for (int b = 0; b < MAX_ORDER; b++) begin
        for (int i = 0; i < NUM_DIMS; i++) begin
          d_nxt.x[i][b] = index_i[b*NUM_DIMS + NUM_DIMS - 1 - i];
        end
      end
      // inverse Gray code
      t = d_nxt.x[NUM_DIMS-1] >> 1;
      for (int i = NUM_DIMS - 1; i > 0; i--) begin
        d_nxt.x[i] = d_nxt.x[i] ^ d_nxt.x[i-1];
      end
      d_nxt.x[0]   = d_nxt.x[0] ^ t;
      d_nxt.status = over ? ST_INDEX_ERR : ST_OK;
    end
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vld_i) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

>>> hdl/hilb9_level.sv
// One bit level of axis exchanges and flips, forward for encode, reverse for decode.
`timescale 1ns / 1ps

module hilb9_level #(
  parameter int NUM_DIMS  = 9,
  parameter int MAX_ORDER = 7,
  parameter int LEVEL     = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [hilb9_pkg::ORD_W-1:0] ord,
  input  logic                        vld_i,
  output logic                        ready_o,
  input  hilb9_pkg::stage_t           d_i,
  output logic                        vld_o,
  input  logic                        ready_i,
  output hilb9_pkg::stage_t           d_o
);
  import hilb9_pkg::*;

  // encode walks levels from the top, decode from the bottom
  localparam int     K_ENC = MAX_ORDER - 1 - LEVEL;
  localparam int     K_DEC = LEVEL + 1;
  localparam coord_t Q_ENC = coord_t'(1 << K_ENC);
  localparam coord_t Q_DEC = coord_t'(1 << K_DEC);

  logic   vld_r;
  stage_t d_r;
  stage_t d_nxt;
  logic   enc_en;
  logic   dec_en;

  assign enc_en = !d_i.dec && (K_ENC >= 1) && (int'(ord) > K_ENC);
  assign dec_en = d_i.dec && (int'(ord) > K_DEC);

  always_comb begin
    d_nxt = d_i;
    if (enc_en) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        d_nxt.x = axis_step(d_nxt.x, DIM_IW'(i), Q_ENC);
      end
    end else if (dec_en) begin
      for (int i = NUM_DIMS - 1; i >= 0; i--) begin
        d_nxt.x = axis_step(d_nxt.x, DIM_IW'(i), Q_DEC);
      end
    end
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vld_i) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

>>> hdl/hilb9_back.sv
// Exit stage: Gray code and bit interleave for encode, result register.
`timescale 1ns / 1ps

module hilb9_back #(
  parameter int NUM_DIMS  = 9,
  parameter int MAX_ORDER = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_i,
  output logic              ready_o,
  input  hilb9_pkg::stage_t d_i,
  output logic              vld_o,
  input  logic              ready_i,
  output hilb9_pkg::res_t   res_o
);
  import hilb9_pkg::*;

  logic             vld_r;
  res_t             res_r;
  res_t             res_nxt;
  coord_arr_t       x;
  coord_t           t;
  logic [IDX_W-1:0] idx;
  logic             ok;

  always_comb begin
    x = d_i.x;
    t = '0;
    // Gray code over the transposed vector
    for (int i = 1; i < NUM_DIMS; i++) begin
      x[i] = x[i] ^ x[i-1];
    end
    for (int k = COORD_W - 1; k >= 1; k--) begin
      if (x[NUM_DIMS-1][k]) t = t ^ coord_t'((1 << k) - 1);
    end
    for (int i = 0; i < NUM_DIMS; i++) begin
      x[i] = x[i] ^ t;
    end
    // MSB-first interleave, dimension 0 first within a level
    idx = '0;
    for (int b = 0; b < MAX_ORDER; b++) begin
      for (int i = 0; i < NUM_DIMS; i++) begin
        idx[b*NUM_DIMS + NUM_DIMS - 1 - i] = x[i][b];
      end
    end
    ok             = (d_i.status == ST_OK);
    res_nxt.status = d_i.status;
    res_nxt.index  = (ok && !d_i.dec) ? idx : '0;
    res_nxt.pos    = (ok && d_i.dec) ? d_i.x : '0;
  end

  assign ready_o = !vld_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && vld_i) begin
      res_r <= res_nxt;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule

>>> hdl/hilbert_9d_index_transcoder.sv
// Top level of the nine-dimension Hilbert index transcoder.
`timescale 1ns / 1ps
//
// Converts NUM_DIMS coordinates of curve_order bits into a Hilbert index
// (in_req_type 0) or an index back into coordinates (in_req_type 1).
// Input and output channels are valid/ready; a request is taken on an edge
// with in_valid and in_ready high, a result leaves with out_valid and
// out_ready high. cfg_wr_en with cfg_wr_data sets curve_order (0 acts as
// 1, values above MAX_ORDER act as MAX_ORDER); write it only while idle.
// Pipeline: one entry stage (range check, unpack, inverse Gray), one stage
// per bit level of axis exchanges (MAX_ORDER-1 of them, at least one), and
// one exit stage (Gray code, interleave, result register). The pipe takes
// one request every cycle while out_ready does not stall it.
// Each stage holds its own valid bit; a stalled receiver backs the pipe up
// stage by stage, and bubbles are squeezed out, so in_ready drops only once
// every stage holds a request. Nothing is dropped or repeated.
// Reset empties the pipe and sets curve_order to 7 (clamped to MAX_ORDER).
// Out-of-range requests return status 1 or 2 with all other fields zero.
//
module hilbert_9d_index_transcoder #(
  parameter int NUM_DIMS  = 9,
  parameter int MAX_ORDER = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [6:0]  in_coord_0,
  input  logic [6:0]  in_coord_1,
  input  logic [6:0]  in_coord_2,
  input  logic [6:0]  in_coord_3,
  input  logic [6:0]  in_coord_4,
  input  logic [6:0]  in_coord_5,
  input  logic [6:0]  in_coord_6,
  input  logic [6:0]  in_coord_7,
  input  logic [6:0]  in_coord_8,
  input  logic [62:0] in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [62:0] out_hilbert_index,
  output logic [6:0]  out_pos_0,
  output logic [6:0]  out_pos_1,
  output logic [6:0]  out_pos_2,
  output logic [6:0]  out_pos_3,
  output logic [6:0]  out_pos_4,
  output logic [6:0]  out_pos_5,
  output logic [6:0]  out_pos_6,
  output logic [6:0]  out_pos_7,
  output logic [6:0]  out_pos_8
);
  import hilb9_pkg::*;

  localparam int NLVL = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;
  localparam logic [ORD_W-1:0] ORD_MAX = ORD_W'(MAX_ORDER);

  // effective curve order, already clamped
  logic [ORD_W-1:0] ord_r;
  logic [ORD_W-1:0] ord_nxt;

  coord_arr_t coord_in;
  res_t       res;

  // stage k feeds level k; entry k = NLVL feeds the exit stage
  logic   vld [NLVL+1];
  logic   rdy [NLVL+1];
  stage_t dat [NLVL+1];

  always_comb begin
    ord_nxt = cfg_wr_data;
    if (ord_nxt == '0) ord_nxt = ORD_W'(1);
    if (ord_nxt > ORD_MAX) ord_nxt = ORD_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= (ORD_MAX < ORD_W'(7)) ? ORD_MAX : ORD_W'(7);
    end else if (cfg_wr_en) begin
      ord_r <= ord_nxt;
    end
  end

  assign coord_in = {in_coord_8, in_coord_7, in_coord_6, in_coord_5, in_coord_4,
                     in_coord_3, in_coord_2, in_coord_1, in_coord_0};

  hilb9_front #(
    .NUM_DIMS  (NUM_DIMS),
    .MAX_ORDER (MAX_ORDER)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ord      (ord_r),
    .vld_i    (in_valid),
    .ready_o  (in_ready),
    .req_type (in_req_type),
    .coord_i  (coord_in),
    .index_i  (in_index),
    .vld_o    (vld[0]),
    .ready_i  (rdy[0]),
    .d_o      (dat[0])
  );

  for (genvar g = 0; g < NLVL; g++) begin : g_lvl
    hilb9_level #(
      .NUM_DIMS  (NUM_DIMS),
      .MAX_ORDER (MAX_ORDER),
      .LEVEL     (g)
    ) u_level (
      .clk     (clk),
      .rst_n   (rst_n),
      .ord     (ord_r),
      .vld_i   (vld[g]),
      .ready_o (rdy[g]),
      .d_i     (dat[g]),
      .vld_o   (vld[g+1]),
      .ready_i (rdy[g+1]),
      .d_o     (dat[g+1])
    );
  end

  hilb9_back #(
    .NUM_DIMS  (NUM_DIMS),
    .MAX_ORDER (MAX_ORDER)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (vld[NLVL]),
    .ready_o (rdy[NLVL]),
    .d_i     (dat[NLVL]),
    .vld_o   (out_valid),
    .ready_i (out_ready),
    .res_o   (res)
  );

  assign out_status        = res.status;
  assign out_hilbert_index = res.index;
  assign out_pos_0         = res.pos[0];
  assign out_pos_1         = res.pos[1];
  assign out_pos_2         = res.pos[2];
  assign out_pos_3         = res.pos[3];
  assign out_pos_4         = res.pos[4];
  assign out_pos_5         = res.pos[5];
  assign out_pos_6         = res.pos[6];
  assign out_pos_7         = res.pos[7];
  assign out_pos_8         = res.pos[8];

  // an empty exit register means the whole ready chain is open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_COORD_ERR ||
                   out_status == ST_INDEX_ERR))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_hilbert_index == '0 && res.pos == '0)
    else $error("error result carries data");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hilbert_index != '0 |-> res.pos == '0)
    else $error("encode result carries coordinates");

  a_ord_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_wr_en) |-> ord_r >= ORD_W'(1) && ord_r <= ORD_MAX)
    else $error("curve order outside clamp range");

endmodule

>>> bench/hilb_tb_pkg.sv
// Request kinds and block dimensions shared by the Hilbert transcoder bench.
`timescale 1ns / 1ps

package hilb_tb_pkg;

  localparam int NDIMS     = 9;  // dimensions the block is built with
  localparam int TOP_ORDER = 7;  // largest curve order the block supports

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_kind_t;

endpackage

>>> bench/hilb_checker.sv
// Result predictor and scoreboard for the Hilbert index transcoder.
`timescale 1ns / 1ps

module hilb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [6:0]  in_coord_0,
  input  logic [6:0]  in_coord_1,
  input  logic [6:0]  in_coord_2,
  input  logic [6:0]  in_coord_3,
  input  logic [6:0]  in_coord_4,
  input  logic [6:0]  in_coord_5,
  input  logic [6:0]  in_coord_6,
  input  logic [6:0]  in_coord_7,
  input  logic [6:0]  in_coord_8,
  input  logic [62:0] in_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [62:0] out_hilbert_index,
  input  logic [6:0]  out_pos_0,
  input  logic [6:0]  out_pos_1,
  input  logic [6:0]  out_pos_2,
  input  logic [6:0]  out_pos_3,
  input  logic [6:0]  out_pos_4,
  input  logic [6:0]  out_pos_5,
  input  logic [6:0]  out_pos_6,
  input  logic [6:0]  out_pos_7,
  input  logic [6:0]  out_pos_8,
  output int          fail_count,
  output int          awaiting,
  output int          checked
);
  import hilb9_pkg::*;
  import hilb_tb_pkg::*;

  coord_arr_t in_pt;
  coord_arr_t out_pt;
  assign in_pt  = {in_coord_8, in_coord_7, in_coord_6, in_coord_5, in_coord_4,
                   in_coord_3, in_coord_2, in_coord_1, in_coord_0};
  assign out_pt = {out_pos_8, out_pos_7, out_pos_6, out_pos_5, out_pos_4,
                   out_pos_3, out_pos_2, out_pos_1, out_pos_0};

  // Swap or invert the bits below q between axis 0 and axis a.
  function automatic coord_arr_t fold_axis(coord_arr_t v, int a, coord_t q);
    coord_arr_t w;
    coord_t     lowm;
    coord_t     d;
    w    = v;
    lowm = q - coord_t'(1);
    if ((v[a] & q) != '0) begin
      w[0] = v[0] ^ lowm;
    end else begin
      d    = (v[0] ^ v[a]) & lowm;
      w[0] = v[0] ^ d;
      w[a] = v[a] ^ d;
    end
    return w;
  endfunction

  function automatic res_t predict_result(logic kind, coord_arr_t c, logic [62:0] ix,
                                          logic [2:0] reg_order);
    res_t        r;
    coord_arr_t  v;
    coord_t      flip;
    logic [62:0] acc;
    logic [63:0] span;
    bit          bad;
    int          o;
    int          q;
    int          i;
    int          b;
    r = '0;
    o = reg_order;
    if (o < 1) o = 1;
    if (o > TOP_ORDER) o = TOP_ORDER;
    if (kind == REQ_ENCODE) begin
      bad = 0;
      for (i = 0; i < NDIMS; i++) begin
        if (int'(c[i]) > (1 << o) - 1) bad = 1;
      end
      if (bad) begin
        r.status = ST_COORD_ERR;
      end else begin
        v = c;
        for (q = 1 << (o - 1); q > 1; q = q >> 1) begin
          for (i = 0; i < NDIMS; i++) v = fold_axis(v, i, coord_t'(q));
        end
        for (i = 1; i < NDIMS; i++) v[i] = v[i] ^ v[i-1];
        flip = '0;
        for (q = 1 << (o - 1); q > 1; q = q >> 1) begin
          if ((v[NDIMS-1] & coord_t'(q)) != '0) flip = flip ^ coord_t'(q - 1);
        end
        for (i = 0; i < NDIMS; i++) v[i] = v[i] ^ flip;
        // top bit level first, dimension 0 most significant within a level
        acc = '0;
        for (b = o - 1; b >= 0; b--) begin
          for (i = 0; i < NDIMS; i++) acc = {acc[61:0], v[i][b]};
        end
        r.status = ST_OK;
        r.index  = acc;
      end
    end else begin
      span = 64'd1 << (NDIMS * o);
      if ({1'b0, ix} >= span) begin
        r.status = ST_INDEX_ERR;
      end else begin
        v   = '0;
        acc = ix;
        for (b = 0; b < o; b++) begin
          for (i = NDIMS - 1; i >= 0; i--) begin
            v[i][b] = acc[0];
            acc     = acc >> 1;
          end
        end
        flip = v[NDIMS-1] >> 1;
        for (i = NDIMS - 1; i > 0; i--) v[i] = v[i] ^ v[i-1];
        v[0] = v[0] ^ flip;
        for (q = 2; q < (1 << o); q = q << 1) begin
          for (i = NDIMS - 1; i >= 0; i--) v = fold_axis(v, i, coord_t'(q));
        end
        r.status = ST_OK;
        r.pos    = v;
      end
    end
    return r;
  endfunction

  res_t       expected_q[$];
  res_t       want;
  res_t       got;
  logic [2:0] order_q;
  int         fails;
  int         seen;

  initial begin
    fails   = 0;
    seen    = 0;
    order_q = 3'd7;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_q.delete();
      order_q = 3'd7;
    end else begin
      // a request taken on this edge still sees the old order
      if (in_valid && in_ready) begin
        expected_q = {expected_q,
                      predict_result(in_req_type, in_pt, in_index, order_q)};
      end
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.index  = out_hilbert_index;
        got.pos    = out_pt;
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual status %0d index %0h",
                   $time, got.status, got.index);
        end else begin
          want = expected_q.pop_front();
          seen++;
          if (got.status !== want.status) begin
            fails++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
          if (got.index !== want.index) begin
            fails++;
            $display("%0t: index expected %0h actual %0h", $time, want.index, got.index);
          end
          for (int k = 0; k < NDIMS; k++) begin
            if (got.pos[k] !== want.pos[k]) begin
              fails++;
              $display("%0t: pos_%0d expected %0d actual %0d", $time, k, want.pos[k],
                       got.pos[k]);
            end
          end
        end
      end
      if (cfg_wr_en) order_q = cfg_wr_data;
    end
    fail_count <= fails;
    awaiting   <= expected_q.size();
    checked    <= seen;
  end

endmodule

>>> bench/tb_top.sv
// Stimulus, handshake pacing and verdict for the Hilbert index transcoder.
`timescale 1ns / 1ps

module tb_top;
  import hilb9_pkg::*;
  import hilb_tb_pkg::*;

  // Idle mixes applied per phase of the random part.
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  localparam int WATCHDOG_LIMIT = 2000;          // cycles without any handshake
  localparam int SETTLE         = TOP_ORDER + 5; // pipe depth plus margin
  localparam int PHASE_ITEMS    = 148;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = 3'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [6:0]  in_coord_0 = '0;
  logic [6:0]  in_coord_1 = '0;
  logic [6:0]  in_coord_2 = '0;
  logic [6:0]  in_coord_3 = '0;
  logic [6:0]  in_coord_4 = '0;
  logic [6:0]  in_coord_5 = '0;
  logic [6:0]  in_coord_6 = '0;
  logic [6:0]  in_coord_7 = '0;
  logic [6:0]  in_coord_8 = '0;
  logic [62:0] in_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [62:0] out_hilbert_index;
  logic [6:0]  out_pos_0, out_pos_1, out_pos_2, out_pos_3, out_pos_4;
  logic [6:0]  out_pos_5, out_pos_6, out_pos_7, out_pos_8;

  int fail_count;
  int awaiting;
  int checked;
  int sent = 0;
  int idle_pct = 0;   // chance in 100 that the sender holds off a cycle
  int stall_pct = 0;  // chance in 100 that the receiver stalls a cycle
  int wd_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hilbert_9d_index_transcoder #(
    .NUM_DIMS (NDIMS),
    .MAX_ORDER(TOP_ORDER)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_coord_0       (in_coord_0),
    .in_coord_1       (in_coord_1),
    .in_coord_2       (in_coord_2),
    .in_coord_3       (in_coord_3),
    .in_coord_4       (in_coord_4),
    .in_coord_5       (in_coord_5),
    .in_coord_6       (in_coord_6),
    .in_coord_7       (in_coord_7),
    .in_coord_8       (in_coord_8),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_hilbert_index(out_hilbert_index),
    .out_pos_0        (out_pos_0),
    .out_pos_1        (out_pos_1),
    .out_pos_2        (out_pos_2),
    .out_pos_3        (out_pos_3),
    .out_pos_4        (out_pos_4),
    .out_pos_5        (out_pos_5),
    .out_pos_6        (out_pos_6),
    .out_pos_7        (out_pos_7),
    .out_pos_8        (out_pos_8)
  );

  // The checker watches both channels and the config port on its own.
  hilb_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_coord_0       (in_coord_0),
    .in_coord_1       (in_coord_1),
    .in_coord_2       (in_coord_2),
    .in_coord_3       (in_coord_3),
    .in_coord_4       (in_coord_4),
    .in_coord_5       (in_coord_5),
    .in_coord_6       (in_coord_6),
    .in_coord_7       (in_coord_7),
    .in_coord_8       (in_coord_8),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_hilbert_index(out_hilbert_index),
    .out_pos_0        (out_pos_0),
    .out_pos_1        (out_pos_1),
    .out_pos_2        (out_pos_2),
    .out_pos_3        (out_pos_3),
    .out_pos_4        (out_pos_4),
    .out_pos_5        (out_pos_5),
    .out_pos_6        (out_pos_6),
    .out_pos_7        (out_pos_7),
    .out_pos_8        (out_pos_8),
    .fail_count       (fail_count),
    .awaiting         (awaiting),
    .checked          (checked)
  );

  // Receiver: a fresh stall decision every cycle, weighted by the phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Watchdog: any handshake on either channel restarts the count, so a hung
  // pipe ends the run instead of spinning forever.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      wd_count <= 0;
    end else if (wd_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      wd_count <= wd_count + 1;
    end
  end

  task automatic set_idle(idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SEND: begin
        idle_pct  = 48;
        stall_pct = 0;
      end
      IDLE_RECV: begin
        idle_pct  = 0;
        stall_pct = 48;
      end
      default: begin
        idle_pct  = 15;
        stall_pct = 15;
      end
    endcase
  endtask

  // Offer one request and return on the edge that takes it. Entered and left
  // at a rising edge; valid is only lowered during a gap, so back-to-back
  // requests keep it high with a single assignment per edge.
  task automatic send_req(req_kind_t kind, coord_arr_t c, logic [62:0] ix);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_coord_0  <= c[0];
    in_coord_1  <= c[1];
    in_coord_2  <= c[2];
    in_coord_3  <= c[3];
    in_coord_4  <= c[4];
    in_coord_5  <= c[5];
    in_coord_6  <= c[6];
    in_coord_7  <= c[7];
    in_coord_8  <= c[8];
    in_index    <= ix;
    // ready is settled by the falling edge, ahead of the edge that samples it
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // Hold off the sender until every outstanding request has its result,
  // then let the pipe settle. The extra edge lets the checker count the
  // request taken on the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with the pipe empty.
  task automatic write_order(logic [2:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // One random request at effective order o. Most requests are in range;
  // at orders below the top a tenth are pushed out of the grid or curve.
  task automatic rand_req(int o);
    coord_arr_t  c;
    logic [62:0] ix;
    int          lim;
    lim = (1 << o) - 1;
    ix  = 63'({$urandom, $urandom});
    if ($urandom_range(1, 0) == 0) begin
      for (int k = 0; k < NDIMS; k++) c[k] = coord_t'($urandom_range(lim, 0));
      if (o < TOP_ORDER && $urandom_range(9, 0) == 0) begin
        c[$urandom_range(NDIMS - 1, 0)] = coord_t'($urandom_range(127, lim + 1));
      end
      send_req(REQ_ENCODE, c, ix);
    end else begin
      // coordinates are don't-care on decode: full range
      for (int k = 0; k < NDIMS; k++) c[k] = coord_t'($urandom_range(127, 0));
      if (o < TOP_ORDER) begin
        if ($urandom_range(9, 0) == 0) begin
          ix = ix | (63'd1 << (NDIMS * o + $urandom_range(62 - NDIMS * o, 0)));
        end else begin
          ix = ix & ((63'd1 << (NDIMS * o)) - 63'd1);
        end
      end
      send_req(REQ_DECODE, c, ix);
    end
  endtask

  int         phase_order [9] = '{1, 0, 2, 3, 7, 4, 5, 6, 7};
  coord_arr_t pt;
  int         eff;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling. Top order: corners of the grid and of the
    // index range, with the unused field of each request type loaded.
    set_idle(IDLE_NONE);
    write_order(3'd7);
    send_req(REQ_ENCODE, '0, {63{1'b1}});
    send_req(REQ_ENCODE, {NDIMS{7'd127}}, '0);
    for (int k = 0; k < NDIMS; k++) pt[k] = coord_t'(k * 13 + 1);
    send_req(REQ_ENCODE, pt, 63'h2AAA_AAAA_AAAA_AAAA);
    pt    = '0;
    pt[0] = 7'd64;
    send_req(REQ_ENCODE, pt, '0);
    send_req(REQ_DECODE, {NDIMS{7'd127}}, '0);
    send_req(REQ_DECODE, '0, {63{1'b1}});
    send_req(REQ_DECODE, '0, 63'd1);
    send_req(REQ_DECODE, '0, 63'h4000_0000_0000_0000);
    send_req(REQ_DECODE, '0, 63'h2AAA_AAAA_AAAA_AAAA);
    drain();

    // Order 3: coordinate just past the grid, index just past the curve.
    write_order(3'd3);
    send_req(REQ_ENCODE, {NDIMS{7'd7}}, '0);
    pt    = '0;
    pt[8] = 7'd8;
    send_req(REQ_ENCODE, pt, '0);
    pt    = '0;
    pt[0] = 7'd127;
    send_req(REQ_ENCODE, pt, '0);
    send_req(REQ_DECODE, '0, (63'd1 << 27) - 63'd1);
    send_req(REQ_DECODE, '0, 63'd1 << 27);
    send_req(REQ_DECODE, '0, {63{1'b1}});
    drain();

    // Order zero behaves as order one.
    write_order(3'd0);
    send_req(REQ_ENCODE, {NDIMS{7'd1}}, '0);
    pt    = '0;
    pt[4] = 7'd2;
    send_req(REQ_ENCODE, pt, '0);
    send_req(REQ_DECODE, '0, 63'd511);
    send_req(REQ_DECODE, '0, 63'd512);
    drain();

    // Random part: one phase per entry of phase_order, idle mix rotating.
    for (int p = 0; p < 9; p++) begin
      write_order(3'(phase_order[p]));
      eff = (phase_order[p] == 0) ? 1 : phase_order[p];
      set_idle(idle_mode_t'(p % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase, let the pipe run dry once before carrying on
        if (n == PHASE_ITEMS / 2) drain();
        rand_req(eff);
      end
      drain();
    end

    $display("Covered %0d encode/decode requests at curve orders 0 to 7, in range and out,",
             sent);
    $display("under four idle mixes; %0d results compared.", checked);
    if (fail_count == 0 && awaiting == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/hilb9_pkg.sv
hdl/hilb9_front.sv
hdl/hilb9_level.sv
hdl/hilb9_back.sv
hdl/hilbert_9d_index_transcoder.sv
bench/hilb_tb_pkg.sv
bench/hilb_checker.sv
bench/tb_top.sv
